/* rtl/core/ledpdb_pkg.sv */
package ledpdb_pkg;

  localparam int unsigned TickW    = 32;
  localparam int unsigned TickIdxW = 5;
  localparam int unsigned ModeW    = 4;
  localparam int unsigned CntW     = 32;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned BudgetW  = 32;
  localparam int unsigned TickRegW = 16;
  localparam int unsigned CfgIdxW  = 3;

  // budget / 100 is (budget >> 2) / 25, done with an exact reciprocal
  localparam int unsigned RecipW     = 31;
  localparam int unsigned RecipShift = 35;
  localparam logic [RecipW-1:0] Recip25 = 31'd1374389535;
  localparam int unsigned DivW = 26;
  localparam int unsigned LimW = 33;
  localparam logic [6:0] PercentScale = 7'd100;

  // load quotient below 128 covers every load under 100
  localparam int unsigned LoadW    = 7;
  localparam int unsigned LoadIdxW = 3;
  localparam int unsigned LdSteps  = 2;
  localparam int unsigned LdStages = (LoadW + LdSteps - 1) / LdSteps;

  localparam int unsigned DigitW     = 4;
  localparam int unsigned Div10ProdW = 15;
  localparam logic [7:0]  Div10Mul   = 8'd205;
  localparam int unsigned Div10Shift = 11;

  localparam int unsigned LenW = 20;
  localparam int unsigned TotW = 21;
  localparam int unsigned ModSteps  = 4;
  localparam int unsigned ModStages = TickW / ModSteps;
  localparam int unsigned SlotSteps = 4;

  localparam logic [6:0] StrobeMask = 7'h7f;
  localparam logic [6:0] StrobeOn   = 7'd64;
  localparam logic [LevelW-1:0] LedOn  = 8'hff;
  localparam logic [LevelW-1:0] LedOff = 8'h00;

  localparam logic [CfgIdxW-1:0] CfgBudget    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgBlinkOn   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPeriod    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgDigitGap  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRepeatGap = 3'd4;

  localparam logic [BudgetW-1:0]  BudgetRst    = 32'd105000;
  localparam logic [TickRegW-1:0] BlinkOnRst   = 16'd160;
  localparam logic [TickRegW-1:0] PeriodRst    = 16'd400;
  localparam logic [TickRegW-1:0] DigitGapRst  = 16'd1200;
  localparam logic [TickRegW-1:0] RepeatGapRst = 16'd3200;
  localparam logic [DivW-1:0]     DivRst       = 26'd1050;
  localparam logic [LimW-1:0]     LimRst       = 33'd105000;

  localparam int unsigned NStages = 3 + LdStages + 3 + ModStages + 2;

  typedef struct packed {
    logic dark;
    logic strobe;
    logic strobe_lit;
    logic div_zero;
  } ctl_t;

  typedef struct packed {
    logic [LenW-1:0] tens_span;
    logic [TotW-1:0] units_start;
    logic [TotW-1:0] units_end;
    logic [TotW-1:0] total;
    logic            tens_nz;
    logic            units_nz;
  } geo_t;

endpackage

/* rtl/core/led_percent_digit_blinker_top.sv */
// throughput: one item per cycle while the output is not stalled; the pipeline
//   depth is set by the 32-step tick modulo (four steps per stage) and the 7-step
//   load divider (two steps per stage)
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset: asynchronous, clears all stage valids and loads the register defaults
module led_percent_digit_blinker_top
  import ledpdb_pkg::*;
#(
  parameter int unsigned NUM_MODES = 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [BudgetW-1:0]  cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [TickW-1:0]    tick_time_i,
  input  logic [ModeW-1:0]    mode_index_i,
  input  logic [CntW-1:0]     blocks_counted_i,
  input  logic [CntW-1:0]     peak_cycles_i,
  input  logic [CntW-1:0]     overrun_count_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [LevelW-1:0]   red_level_o,
  output logic [LevelW-1:0]   green_level_o,
  output logic [LevelW-1:0]   blue_level_o
);

  logic adv;
  logic [NStages-1:0] vld_q;

  logic [BudgetW-1:0]  budget_q;
  logic [TickRegW-1:0] on_q, per_q, dgap_q, rgap_q;
  logic [DivW-1:0]     div_q, div_d;
  logic [LimW-1:0]     lim_q, lim_d;
  logic [TickRegW-1:0] per_eff;
  logic [BudgetW+RecipW-3:0] recip_prod;

  // stage 1
  logic [TickW-1:0] s1_t_q;
  logic [ModeW-1:0] s1_mode_q;
  logic [CntW-1:0]  s1_blocks_q, s1_peak_q, s1_ovr_q;
  // stage 2
  ctl_t             s2_ctl_q, s2_ctl_d;
  logic [TickW-1:0] s2_t_q;
  logic [CntW-1:0]  s2_peak_q;
  // load divider, index 0 is stage 3
  ctl_t             ld_ctl_q [LdStages+1];
  logic [TickW-1:0] ld_t_q   [LdStages+1];
  logic [CntW-1:0]  ld_rem_q [LdStages+1];
  logic [LoadW-1:0] ld_quo_q [LdStages+1];
  ctl_t             s3_ctl_d;
  logic [CntW-1:0]  ld_rem_d [LdStages];
  logic [LoadW-1:0] ld_quo_d [LdStages];
  // digits and pattern lengths
  ctl_t              s8_ctl_q;
  logic [TickW-1:0]  s8_t_q;
  logic [DigitW-1:0] s8_tens_q, s8_units_q, s8_tens_d, s8_units_d;
  logic [LoadW-1:0]  load;
  logic [Div10ProdW-1:0] d10_prod;
  logic [LoadW-1:0]  ten_x;
  ctl_t              s9_ctl_q;
  logic [TickW-1:0]  s9_t_q;
  logic              s9_tens_nz_q, s9_units_nz_q;
  logic [LenW-1:0]   s9_tens_span_q, s9_units_span_q, s9_tens_span_d, s9_units_span_d;
  logic [DigitW-1:0] tens_eff, units_eff;
  geo_t              s10_geo_d;
  // tick modulo, index 0 is stage 10
  ctl_t             md_ctl_q [ModStages+1];
  logic [TickW-1:0] md_t_q   [ModStages+1];
  geo_t             md_geo_q [ModStages+1];
  logic [TotW-1:0]  md_rem_q [ModStages+1];
  logic [TotW-1:0]  md_rem_d [ModStages];
  // stage 19
  ctl_t            s19_ctl_q;
  logic [TotW-1:0] s19_pos_q, s19_pos_d;
  logic            s19_in_tens_q, s19_in_units_q, s19_in_tens_d, s19_in_units_d;
  logic            s19_tens_nz_q, s19_units_nz_q;
  // output stage
  logic [LevelW-1:0] red_q, green_q, blue_q, red_d, green_d, blue_d;

  assign adv        = !vld_q[NStages-1] || !out_stall_i;
  assign in_stall_o = !adv;
  assign per_eff    = (per_q == '0) ? TickRegW'(1) : per_q;

  assign recip_prod = (BudgetW+RecipW-2)'(budget_q[BudgetW-1:2])
                      * (BudgetW+RecipW-2)'(Recip25);
  assign div_d      = recip_prod[RecipShift +: DivW];
  assign lim_d      = LimW'(div_q) * LimW'(PercentScale);

  always_comb begin
    s2_ctl_d.dark       = !({1'b0, s1_mode_q} < (ModeW+1)'(NUM_MODES)) || (s1_blocks_q == '0);
    s2_ctl_d.strobe     = (s1_ovr_q != '0);
    s2_ctl_d.strobe_lit = ((s1_t_q[6:0] & StrobeMask) < StrobeOn);
    s2_ctl_d.div_zero   = 1'b0;

    s3_ctl_d          = s2_ctl_q;
    s3_ctl_d.div_zero = (div_q == '0);
    s3_ctl_d.strobe   = s2_ctl_q.strobe
                        || ((div_q != '0) && ({1'b0, s2_peak_q} >= lim_q));
  end

  always_comb begin
    int unsigned b;
    logic [CntW:0] sub;
    b   = 0;
    sub = '0;
    for (int k = 0; k < LdStages; k++) begin
      ld_rem_d[k] = ld_rem_q[k];
      ld_quo_d[k] = ld_quo_q[k];
      for (int j = 0; j < LdSteps; j++) begin
        if (k * LdSteps + j < LoadW) begin
          b   = LoadW - 1 - (k * LdSteps + j);
          sub = (CntW+1)'(div_q) << b;
          if ({1'b0, ld_rem_d[k]} >= sub) begin
            ld_rem_d[k] = ld_rem_d[k] - sub[CntW-1:0];
            ld_quo_d[k][LoadIdxW'(b)] = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    load       = ld_ctl_q[LdStages].div_zero ? '0 : ld_quo_q[LdStages];
    d10_prod   = Div10ProdW'(load) * Div10ProdW'(Div10Mul);
    s8_tens_d  = d10_prod[Div10Shift +: DigitW];
    ten_x      = LoadW'({s8_tens_d, 3'b000}) + LoadW'({s8_tens_d, 1'b0});
    s8_units_d = DigitW'(load - ten_x);

    tens_eff        = (s8_tens_q == '0) ? DigitW'(1) : s8_tens_q;
    units_eff       = (s8_units_q == '0) ? DigitW'(1) : s8_units_q;
    s9_tens_span_d  = LenW'(tens_eff) * LenW'(per_eff);
    s9_units_span_d = LenW'(units_eff) * LenW'(per_eff);

    s10_geo_d.tens_span   = s9_tens_span_q;
    s10_geo_d.units_start = TotW'(s9_tens_span_q) + TotW'(dgap_q);
    s10_geo_d.units_end   = s10_geo_d.units_start + TotW'(s9_units_span_q);
    s10_geo_d.total       = s10_geo_d.units_end + TotW'(rgap_q);
    s10_geo_d.tens_nz     = s9_tens_nz_q;
    s10_geo_d.units_nz    = s9_units_nz_q;
  end

  always_comb begin
    logic [TotW:0] r2;
    r2 = '0;
    for (int k = 0; k < ModStages; k++) begin
      md_rem_d[k] = md_rem_q[k];
      for (int j = 0; j < ModSteps; j++) begin
        r2 = {md_rem_d[k], md_t_q[k][TickIdxW'(TickW - 1 - (k * ModSteps + j))]};
        if (r2 >= {1'b0, md_geo_q[k].total}) begin
          r2 = r2 - {1'b0, md_geo_q[k].total};
        end
        md_rem_d[k] = r2[TotW-1:0];
      end
    end
  end

  always_comb begin
    logic [TotW-1:0] phase;
    logic [TotW-1:0] r;
    logic [TotW-1:0] sub;
    logic            lit;
    phase          = md_rem_q[ModStages];
    s19_in_tens_d  = (phase < TotW'(md_geo_q[ModStages].tens_span));
    s19_in_units_d = (phase >= md_geo_q[ModStages].units_start)
                     && (phase < md_geo_q[ModStages].units_end);
    s19_pos_d      = s19_in_tens_d ? phase : phase - md_geo_q[ModStages].units_start;

    r = s19_pos_q;
    for (int b = SlotSteps - 1; b >= 0; b--) begin
      sub = TotW'(per_eff) << b;
      if (r >= sub) begin
        r = r - sub;
      end
    end
    lit = (r < TotW'(on_q));

    red_d   = LedOff;
    green_d = LedOff;
    blue_d  = LedOff;
    if (!s19_ctl_q.dark) begin
      if (s19_ctl_q.strobe) begin
        if (s19_ctl_q.strobe_lit) red_d = LedOn;
      end else if (s19_in_tens_q && lit) begin
        if (s19_tens_nz_q) green_d = LedOn;
        else blue_d = LedOn;
      end else if (s19_in_units_q && lit) begin
        if (s19_units_nz_q) red_d = LedOn;
        else blue_d = LedOn;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      budget_q <= BudgetRst;
      on_q     <= BlinkOnRst;
      per_q    <= PeriodRst;
      dgap_q   <= DigitGapRst;
      rgap_q   <= RepeatGapRst;
      div_q    <= DivRst;
      lim_q    <= LimRst;
    end else begin
      div_q <= div_d;
      lim_q <= lim_d;
      if (adv) begin
        vld_q <= {vld_q[NStages-2:0], in_valid_i};
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgBudget:    budget_q <= cfg_data_i;
          CfgBlinkOn:   on_q     <= cfg_data_i[TickRegW-1:0];
          CfgPeriod:    per_q    <= cfg_data_i[TickRegW-1:0];
          CfgDigitGap:  dgap_q   <= cfg_data_i[TickRegW-1:0];
          CfgRepeatGap: rgap_q   <= cfg_data_i[TickRegW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_t_q      <= tick_time_i;
      s1_mode_q   <= mode_index_i;
      s1_blocks_q <= blocks_counted_i;
      s1_peak_q   <= peak_cycles_i;
      s1_ovr_q    <= overrun_count_i;

      s2_ctl_q  <= s2_ctl_d;
      s2_t_q    <= s1_t_q;
      s2_peak_q <= s1_peak_q;

      ld_ctl_q[0] <= s3_ctl_d;
      ld_t_q[0]   <= s2_t_q;
      ld_rem_q[0] <= s2_peak_q;
      ld_quo_q[0] <= '0;
      for (int k = 0; k < LdStages; k++) begin
        ld_ctl_q[k+1] <= ld_ctl_q[k];
        ld_t_q[k+1]   <= ld_t_q[k];
        ld_rem_q[k+1] <= ld_rem_d[k];
        ld_quo_q[k+1] <= ld_quo_d[k];
      end

      s8_ctl_q   <= ld_ctl_q[LdStages];
      s8_t_q     <= ld_t_q[LdStages];
      s8_tens_q  <= s8_tens_d;
      s8_units_q <= s8_units_d;

      s9_ctl_q        <= s8_ctl_q;
      s9_t_q          <= s8_t_q;
      s9_tens_nz_q    <= (s8_tens_q != '0);
      s9_units_nz_q   <= (s8_units_q != '0);
      s9_tens_span_q  <= s9_tens_span_d;
      s9_units_span_q <= s9_units_span_d;

      md_ctl_q[0] <= s9_ctl_q;
      md_t_q[0]   <= s9_t_q;
      md_geo_q[0] <= s10_geo_d;
      md_rem_q[0] <= '0;
      for (int k = 0; k < ModStages; k++) begin
        md_ctl_q[k+1] <= md_ctl_q[k];
        md_t_q[k+1]   <= md_t_q[k];
        md_geo_q[k+1] <= md_geo_q[k];
        md_rem_q[k+1] <= md_rem_d[k];
      end

      s19_ctl_q      <= md_ctl_q[ModStages];
      s19_pos_q      <= s19_pos_d;
      s19_in_tens_q  <= s19_in_tens_d;
      s19_in_units_q <= s19_in_units_d;
      s19_tens_nz_q  <= md_geo_q[ModStages].tens_nz;
      s19_units_nz_q <= md_geo_q[ModStages].units_nz;

      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign out_valid_o   = vld_q[NStages-1];
  assign red_level_o   = red_q;
  assign green_level_o = green_q;
  assign blue_level_o  = blue_q;

  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("output stall not passed to input");

  a_one_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({red_level_o != LedOff, green_level_o != LedOff,
                              blue_level_o != LedOff}))
    else $error("more than one color lit");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NStages-2] && !in_stall_o |=> out_valid_o)
    else $error("last stage item did not reach output");

endmodule

/* tb/sv/led_percent_digit_blinker_top_tb.sv */
module led_percent_digit_blinker_top_tb
  import ledpdb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumModes      = 9;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 30;
  localparam int unsigned IdlePercent   = 31;

  typedef struct {
    logic [TickW-1:0] tick;
    logic [ModeW-1:0] mode;
    logic [CntW-1:0]  blocks;
    logic [CntW-1:0]  peak;
    logic [CntW-1:0]  overruns;
  } load_sample_t;

  typedef struct {
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
  } led_rgb_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [BudgetW-1:0] cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [TickW-1:0]   tick_time_i;
  logic [ModeW-1:0]   mode_index_i;
  logic [CntW-1:0]    blocks_counted_i;
  logic [CntW-1:0]    peak_cycles_i;
  logic [CntW-1:0]    overrun_count_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [LevelW-1:0]  red_level_o;
  logic [LevelW-1:0]  green_level_o;
  logic [LevelW-1:0]  blue_level_o;

  // shadow copy of the register file
  logic [BudgetW-1:0]  budget_q     = BudgetRst;
  logic [TickRegW-1:0] blink_on_q   = BlinkOnRst;
  logic [TickRegW-1:0] period_q     = PeriodRst;
  logic [TickRegW-1:0] digit_gap_q  = DigitGapRst;
  logic [TickRegW-1:0] repeat_gap_q = RepeatGapRst;

  led_rgb_t    led_expect_q[$];
  int unsigned err_cnt   = 0;
  int unsigned stuck_cnt = 0;
  int unsigned hold_req  = 0;
  int unsigned hold_left = 0;
  bit          idle_en   = 1'b1;

  led_percent_digit_blinker_top #(
    .NUM_MODES(NumModes)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .tick_time_i     (tick_time_i),
    .mode_index_i    (mode_index_i),
    .blocks_counted_i(blocks_counted_i),
    .peak_cycles_i   (peak_cycles_i),
    .overrun_count_i (overrun_count_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .red_level_o     (red_level_o),
    .green_level_o   (green_level_o),
    .blue_level_o    (blue_level_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic led_rgb_t predict_led(load_sample_t s);
    led_rgb_t          rgb;
    longint unsigned   divisor, load, tens, units, period;
    longint unsigned   tens_span, units_span, units_start, total, phase;
    rgb.red   = LedOff;
    rgb.green = LedOff;
    rgb.blue  = LedOff;
    if (s.mode < NumModes && s.blocks != '0) begin
      divisor = 64'(budget_q / PercentScale);
      load = (divisor != 0) ? 64'(s.peak) / divisor : 64'd0;
      if (s.overruns != '0 || load >= 64'(PercentScale)) begin
        if (s.tick[6:0] < StrobeOn) rgb.red = LedOn;
      end else begin
        tens        = load / 10;
        units       = load % 10;
        period      = (period_q != '0) ? 64'(period_q) : 64'd1;
        tens_span   = ((tens != 0) ? tens : 64'd1) * period;
        units_span  = ((units != 0) ? units : 64'd1) * period;
        units_start = tens_span + 64'(digit_gap_q);
        total       = units_start + units_span + 64'(repeat_gap_q);
        phase       = 64'(s.tick) % total;
        if (phase < tens_span) begin
          if ((phase % period) < 64'(blink_on_q)) begin
            if (tens != 0) rgb.green = LedOn;
            else rgb.blue = LedOn;
          end
        end else if (phase >= units_start && phase < units_start + units_span) begin
          if (((phase - units_start) % period) < 64'(blink_on_q)) begin
            if (units != 0) rgb.red = LedOn;
            else rgb.blue = LedOn;
          end
        end
      end
    end
    return rgb;
  endfunction

  function automatic load_sample_t sample_of(logic [TickW-1:0] tick, logic [ModeW-1:0] mode,
                                             logic [CntW-1:0] blocks, logic [CntW-1:0] peak,
                                             logic [CntW-1:0] overruns);
    load_sample_t s;
    s.tick     = tick;
    s.mode     = mode;
    s.blocks   = blocks;
    s.peak     = peak;
    s.overruns = overruns;
    return s;
  endfunction

  // mostly loads under 100 with random content, the rest strobe, dark and noise
  function automatic load_sample_t rand_sample();
    load_sample_t    s;
    longint unsigned divisor, peak_w;
    int unsigned     pick;
    pick     = $urandom_range(0, 99);
    s.tick   = $urandom;
    s.mode   = 4'($urandom_range(0, NumModes - 1));
    s.blocks = $urandom;
    if (s.blocks == '0) s.blocks = 1;
    s.overruns = '0;
    divisor = 64'(budget_q / PercentScale);
    if (divisor == 0) begin
      s.peak = $urandom;
    end else begin
      peak_w = 64'($urandom_range(0, 99)) * divisor + 64'($urandom) % divisor;
      s.peak = (peak_w > 64'hFFFF_FFFF) ? $urandom : peak_w[31:0];
    end
    if (pick >= 94) begin
      s.blocks = '0;
    end else if (pick >= 88) begin
      s.mode = 4'($urandom_range(0, 15));
    end else if (pick >= 82) begin
      s.peak = $urandom;
    end else if (pick >= 70) begin
      s.overruns = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 3) : $urandom;
      if (s.overruns == '0) s.overruns = 1;
    end
    return s;
  endfunction

  task automatic send_sample(load_sample_t s);
    while (idle_en && $urandom_range(0, 99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    tick_time_i      <= s.tick;
    mode_index_i     <= s.mode;
    blocks_counted_i <= s.blocks;
    peak_cycles_i    <= s.peak;
    overrun_count_i  <= s.overruns;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    led_expect_q.push_back(predict_led(s));
  endtask

  task automatic wait_led_drain();
    in_valid_i <= 1'b0;
    while (led_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [BudgetW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CfgBudget:    budget_q     = data;
      CfgBlinkOn:   blink_on_q   = data[TickRegW-1:0];
      CfgPeriod:    period_q     = data[TickRegW-1:0];
      CfgDigitGap:  digit_gap_q  = data[TickRegW-1:0];
      CfgRepeatGap: repeat_gap_q = data[TickRegW-1:0];
      default: ;
    endcase
  endtask

  // upper data bits of the 16-bit registers carry junk on purpose
  task automatic cfg_all(logic [BudgetW-1:0] budget, logic [TickRegW-1:0] on_ticks,
                         logic [TickRegW-1:0] period, logic [TickRegW-1:0] digit_gap,
                         logic [TickRegW-1:0] repeat_gap);
    wait_led_drain();
    repeat (2) @(posedge clk_i);
    cfg_write(CfgBudget, budget);
    cfg_write(CfgBlinkOn, {16'($urandom), on_ticks});
    cfg_write(CfgPeriod, {16'($urandom), period});
    cfg_write(CfgDigitGap, {16'($urandom), digit_gap});
    cfg_write(CfgRepeatGap, {16'($urandom), repeat_gap});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cfg_random();
    logic [BudgetW-1:0]  budget;
    logic [TickRegW-1:0] period, on_ticks, digit_gap, repeat_gap;
    budget = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(100, 400000);
    period = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 600));
    on_ticks = 16'($urandom_range(0, int'(period) + 40));
    digit_gap = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2500));
    repeat_gap = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
    cfg_all(budget, on_ticks, period, digit_gap, repeat_gap);
  endtask

  // reset register values, load 57 has tens 2000 long, units from 3200, total 9200
  task automatic test_directed();
    localparam logic [CntW-1:0] Pct = 32'd1050;
    send_sample(sample_of(32'd0, 4'd0, 32'd1, 32'd0, 32'd0));
    send_sample(sample_of(32'd1600, 4'd0, 32'd1, 32'd0, 32'd0));
    send_sample(sample_of(32'hFFFF_FFFF, 4'(NumModes - 1), 32'hFFFF_FFFF, 57 * Pct, 32'd0));
    send_sample(sample_of(32'd0, 4'd8, 32'd1, 57 * Pct, 32'd0));
    send_sample(sample_of(32'd160, 4'd0, 32'd1, 57 * Pct, 32'd0));
    send_sample(sample_of(32'd2500, 4'd0, 32'd1, 57 * Pct, 32'd0));
    send_sample(sample_of(32'd3200, 4'd0, 32'd1, 57 * Pct, 32'd0));
    send_sample(sample_of(32'd3400, 4'd0, 32'd1, 57 * Pct, 32'd0));
    send_sample(sample_of(32'd9199, 4'd0, 32'd1, 57 * Pct, 32'd0));
    send_sample(sample_of(32'd9200, 4'd0, 32'd1, 57 * Pct, 32'd0));
    send_sample(sample_of(32'd1600, 4'd0, 32'd1, 10 * Pct, 32'd0));
    send_sample(sample_of(32'd0, 4'd0, 32'd1, 5 * Pct, 32'd0));
    send_sample(sample_of(32'd1600, 4'd0, 32'd1, 5 * Pct, 32'd0));
    send_sample(sample_of(32'd0, 4'd0, 32'd1, 100 * Pct - 1, 32'd0));
    send_sample(sample_of(32'd0, 4'd0, 32'd1, 100 * Pct, 32'd0));
    send_sample(sample_of(32'd64, 4'd0, 32'd1, 100 * Pct, 32'd0));
    send_sample(sample_of(32'd63, 4'd0, 32'd1, 32'hFFFF_FFFF, 32'd0));
    send_sample(sample_of(32'd0, 4'd0, 32'd1, 32'd0, 32'd1));
    send_sample(sample_of(32'd64, 4'd0, 32'd1, 32'd0, 32'hFFFF_FFFF));
    send_sample(sample_of(32'd127, 4'd0, 32'd1, 32'd0, 32'd1));
    send_sample(sample_of(32'd0, 4'(NumModes), 32'd1, 57 * Pct, 32'd0));
    send_sample(sample_of(32'd0, 4'd15, 32'd1, 57 * Pct, 32'd1));
    send_sample(sample_of(32'd0, 4'd0, 32'd0, 57 * Pct, 32'd1));
    send_sample(sample_of(32'd0, 4'd0, 32'd0, 57 * Pct, 32'd0));
  endtask

  task automatic test_config_extremes();
    cfg_all(32'd0, 16'd160, 16'd400, 16'd1200, 16'd3200);
    repeat (40) send_sample(rand_sample());
    cfg_all(32'd99, 16'd100, 16'd300, 16'd0, 16'd50);
    repeat (40) send_sample(rand_sample());
    cfg_all(32'hFFFF_FFFF, 16'd0, 16'd1, 16'd0, 16'd0);
    repeat (40) send_sample(rand_sample());
    cfg_all(32'd100, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (40) send_sample(rand_sample());
    // zero period behaves as one
    cfg_all(32'd1000, 16'd1, 16'd0, 16'd0, 16'd7);
    repeat (40) send_sample(rand_sample());
    cfg_all(32'd250, 16'd400, 16'd400, 16'd1, 16'd1);
    repeat (40) send_sample(rand_sample());
  endtask

  task automatic test_random_configs();
    for (int unsigned phase = 0; phase < 7; phase++) begin
      cfg_random();
      idle_en = (phase != 3);
      repeat (85) send_sample(rand_sample());
    end
    idle_en = 1'b1;
  endtask

  task automatic test_output_backpressure();
    wait_led_drain();
    idle_en  = 1'b0;
    hold_req = 80;
    repeat (60) send_sample(rand_sample());
    wait_led_drain();
    idle_en = 1'b1;
  endtask

  task automatic test_sender_pause();
    repeat (20) send_sample(rand_sample());
    wait_led_drain();
    repeat (20) send_sample(rand_sample());
  endtask

  // receiver: random stalls plus a counted hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= idle_en && ($urandom_range(0, 99) < IdlePercent);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (led_expect_q.size() == 0) begin
        $error("result transfer with no pending expectation");
        err_cnt++;
      end else begin
        if (red_level_o !== led_expect_q[0].red) begin
          $error("red_level: expected %0d, actual %0d", led_expect_q[0].red, red_level_o);
          err_cnt++;
        end
        if (green_level_o !== led_expect_q[0].green) begin
          $error("green_level: expected %0d, actual %0d", led_expect_q[0].green,
                 green_level_o);
          err_cnt++;
        end
        if (blue_level_o !== led_expect_q[0].blue) begin
          $error("blue_level: expected %0d, actual %0d", led_expect_q[0].blue, blue_level_o);
          err_cnt++;
        end
        void'(led_expect_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stuck_cnt = 0;
    end else if ((in_valid_i && in_stall_o === 1'b0) ||
                 (out_valid_o === 1'b1 && !out_stall_i) || cfg_we_i) begin
      stuck_cnt = 0;
    end else begin
      stuck_cnt++;
      if (stuck_cnt >= WatchdogLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CfgBudget;
    cfg_data_i       <= '0;
    in_valid_i       <= 1'b0;
    tick_time_i      <= '0;
    mode_index_i     <= '0;
    blocks_counted_i <= '0;
    peak_cycles_i    <= '0;
    overrun_count_i  <= '0;
    out_stall_i      <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_random_configs();
    test_output_backpressure();
    test_sender_pause();
    wait_led_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && led_expect_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
